### hdl/ssfd_pkg.sv
// Shared types and constants for the sync-and-sum frame deframer.
`default_nettype none

package ssfd_pkg;

	// Widths of one stream byte and of the largest payload.
	localparam int BYTE_W      = 8;
	localparam int MAX_PAYLOAD = 8;

	// Sync bytes that open every frame.
	localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hFF;
	localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hFE;

	// One recovered frame; the id sits in the lowest bits, payload byte 0 next.
	typedef struct packed {
		logic [MAX_PAYLOAD-1:0][BYTE_W-1:0] payload;
		logic [BYTE_W-1:0]                  id;
	} frame_t;

	localparam int FRAME_W = $bits(frame_t);

	// Frame tracking phases, one-hot.
	typedef enum logic [4:0] {
		PH_HUNT  = 5'b00001,
		PH_SYNC2 = 5'b00010,
		PH_ID    = 5'b00100,
		PH_DATA  = 5'b01000,
		PH_CHECK = 5'b10000
	} phase_t;

endpackage

`default_nettype wire

### hdl/ssfd_framer.sv
// Frame tracker: sync hunt, id and payload capture, running sum and checksum test.
`default_nettype none

module ssfd_framer #(
	parameter int PAYLOAD_BYTES = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic [ssfd_pkg::BYTE_W-1:0] byte_in,
	output logic                            emit,
	output ssfd_pkg::frame_t                frame
);
	import ssfd_pkg::*;

	localparam int CNT_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAYLOAD_BYTES - 1);

	phase_t            phase_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] id_q;
	logic [BYTE_W-1:0] store_q [PAYLOAD_BYTES];

	// Control state: phase, payload counter and running sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			cnt_q   <= '0;
			sum_q   <= '0;
		end else if (step) begin
			unique case (phase_q)
				PH_HUNT: begin
					phase_q <= (byte_in == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
				end
				PH_SYNC2: begin
					phase_q <= (byte_in == SYNC_SECOND) ? PH_ID : PH_HUNT;
				end
				PH_ID: begin
					sum_q   <= byte_in;
					cnt_q   <= '0;
					phase_q <= PH_DATA;
				end
				PH_DATA: begin
					sum_q <= sum_q + byte_in;
					if (cnt_q == CNT_LAST) begin
						phase_q <= PH_CHECK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				PH_CHECK: begin
					phase_q <= PH_HUNT;
				end
				default: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

	// Payload bytes shift in from the top, so byte 0 ends up in entry 0.
	always_ff @(posedge clk) begin
		if (step && phase_q == PH_ID) begin
			id_q <= byte_in;
		end
		if (step && phase_q == PH_DATA) begin
			for (int k = 0; k < PAYLOAD_BYTES - 1; k++) begin
				store_q[k] <= store_q[k+1];
			end
			store_q[PAYLOAD_BYTES-1] <= byte_in;
		end
	end

	// The checksum byte must equal 255 minus the sum, which is its bitwise inverse.
	// This flags the byte on byte_in whether or not it is consumed in this cycle.
	assign emit = (phase_q == PH_CHECK) && (byte_in == ~sum_q);

	// Result fields; bytes past the payload length read as zero.
	always_comb begin
		frame.id = id_q;
		for (int k = 0; k < MAX_PAYLOAD; k++) begin
			frame.payload[k] = '0;
		end
		for (int k = 0; k < PAYLOAD_BYTES; k++) begin
			frame.payload[k] = store_q[k];
		end
	end

endmodule

`default_nettype wire

### hdl/sync_sum_frame_deframer_unit.sv
// Top level of the sync-and-sum frame deframer: input register, frame tracker, result register.
//
//  channel   direction  fields (tdata, lowest bit first)
//  s_axis    in         stream_byte[7:0]
//  m_axis    out        out_id, out_byte0 .. out_byte7 (72 bits)
//
// One byte is taken every cycle while the input register is not stalled. A byte
// is held in the input register until it updates the tracker; a good frame reaches
// the result register at that same edge, as its checksum byte leaves that register.
// Reset clears the phase, the running sum and both valid flags.
// A held result stalls the input register only when that register holds a
// checksum byte that would give a new result.
`default_nettype none

module sync_sum_frame_deframer_unit #(
	parameter int PAYLOAD_BYTES = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [7:0]                   s_axis_tdata,  // stream_byte
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	output logic [ssfd_pkg::FRAME_W-1:0]      m_axis_tdata   // out_id, out_byte0..out_byte7
);
	import ssfd_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              step;
	logic              emit;
	frame_t            frame;
	logic              out_valid_q;
	frame_t            out_data_q;
	logic              out_free;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && (!emit || out_free);
	assign s_axis_tready = !valid_s1 || step;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	ssfd_framer #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_framer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.byte_in(byte_s1),
		.emit   (emit),
		.frame  (frame)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && emit && out_free) begin
			out_data_q <= frame;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

### tb/ssfd_frame_checker.sv
// Checker for the frame deframer: predicts recovered frames from the input items and compares results.
`timescale 1ns / 100ps

module ssfd_frame_checker #(
	parameter int PAYLOAD_BYTES = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	input  wire logic                         s_axis_tready,
	input  wire logic [7:0]                   s_axis_tdata,  // stream_byte
	input  wire logic                         m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	input  wire logic [ssfd_pkg::FRAME_W-1:0] m_axis_tdata,  // out_id, out_byte0..out_byte7
	output int                                mismatches,
	output int                                frames_pending
);

	import ssfd_pkg::*;

	// The checksum is this value minus the running sum.
	localparam logic [BYTE_W-1:0] SUM_TOP = 8'hFF;

	// Predicted tracker state.
	phase_t            trk_phase;
	int                data_idx;
	logic [BYTE_W-1:0] held_id;
	logic [BYTE_W-1:0] held_payload [MAX_PAYLOAD];
	logic [BYTE_W-1:0] run_sum;

	// Frames predicted but not yet seen on the output.
	frame_t frames_due [$];
	int     errs;

	// Advance the predicted tracker by one byte and queue a frame when its checksum holds.
	task automatic track_byte(input logic [BYTE_W-1:0] b);
		frame_t f;
		int     k;
		case (trk_phase)
			PH_SYNC2: begin
				trk_phase = (b == SYNC_SECOND) ? PH_ID : PH_HUNT;
			end
			PH_ID: begin
				held_id   = b;
				run_sum   = b;
				data_idx  = 0;
				trk_phase = PH_DATA;
			end
			PH_DATA: begin
				held_payload[data_idx] = b;
				run_sum  = run_sum + b;
				data_idx = data_idx + 1;
				if (data_idx == PAYLOAD_BYTES) begin
					trk_phase = PH_CHECK;
				end
			end
			PH_CHECK: begin
				trk_phase = PH_HUNT;
				if (b == SUM_TOP - run_sum) begin
					f.id = held_id;
					for (k = 0; k < MAX_PAYLOAD; k++) begin
						f.payload[k] = (k < PAYLOAD_BYTES) ? held_payload[k] : '0;
					end
					frames_due.push_back(f);
				end
			end
			default: begin
				trk_phase = (b == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
			end
		endcase
	endtask

	// Results are checked before the input item of the same edge is tracked.
	always @(posedge clk or negedge arst_n) begin
		frame_t want;
		frame_t got;
		int     k;
		if (!arst_n) begin
			trk_phase = PH_HUNT;
			run_sum   = '0;
			data_idx  = 0;
			errs      = 0;
			frames_due.delete();
			mismatches     <= 0;
			frames_pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = frame_t'(m_axis_tdata);
				if (frames_due.size() == 0) begin
					errs++;
					$display("%0t: result with none expected: expected nothing, got %h",
						$time, m_axis_tdata);
				end else begin
					want = frames_due.pop_front();
					if (got.id !== want.id) begin
						errs++;
						$display("%0t: out_id: expected %02h, got %02h", $time, want.id, got.id);
					end
					for (k = 0; k < MAX_PAYLOAD; k++) begin
						if (got.payload[k] !== want.payload[k]) begin
							errs++;
							$display("%0t: out_byte%0d: expected %02h, got %02h",
								$time, k, want.payload[k], got.payload[k]);
						end
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				track_byte(s_axis_tdata);
			end
			mismatches     <= errs;
			frames_pending <= frames_due.size();
		end
	end

endmodule

### tb/tb_sync_sum_frame_deframer_unit.sv
// Testbench top for the frame deframer: byte stimulus, output back-pressure and the verdict.
`timescale 1ns / 100ps

module tb_sync_sum_frame_deframer_unit;

	import ssfd_pkg::*;

	localparam int PAYLOAD_BYTES = 8;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int ITEM_TARGET   = 450;
	localparam int CALM_FROM     = 390;
	localparam int DRAIN_CYCLES  = 20;

	logic                 clk;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	wire logic            s_axis_tready;
	logic [7:0]           s_axis_tdata  = '0;
	wire logic            m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	wire logic [FRAME_W-1:0] m_axis_tdata;

	int   mismatches;
	int   frames_pending;
	int   cycles    = 0;
	int   counted   = 0;
	int   stall_left = 0;
	logic calm      = 1'b0;

	sync_sum_frame_deframer_unit #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	ssfd_frame_checker #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.frames_pending(frames_pending)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog on the whole run.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	// Output back-pressure in random bursts, none in the final stretch.
	always @(posedge clk) begin
		if (calm) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 17) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Offer one byte, possibly after an idle burst, and return at the edge it is taken.
	task automatic send_byte(input logic [7:0] b, input bit counts);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (counts) begin
			counted++;
		end
	endtask

	// Send a whole frame; a nonzero flip corrupts the checksum.
	task automatic send_frame(input logic [7:0] id, input logic [PAYLOAD_BYTES-1:0][7:0] body,
			input logic [7:0] flip);
		logic [7:0] sum;
		int         k;
		sum = id;
		for (k = 0; k < PAYLOAD_BYTES; k++) begin
			sum = sum + body[k];
		end
		send_byte(SYNC_FIRST, 1'b1);
		send_byte(SYNC_SECOND, 1'b1);
		send_byte(id, 1'b1);
		for (k = 0; k < PAYLOAD_BYTES; k++) begin
			send_byte(body[k], 1'b1);
		end
		send_byte((8'hFF - sum) ^ flip, 1'b1);
	endtask

	// Random payload of one frame.
	function automatic logic [PAYLOAD_BYTES-1:0][7:0] random_body();
		logic [PAYLOAD_BYTES-1:0][7:0] body;
		int k;
		for (k = 0; k < PAYLOAD_BYTES; k++) begin
			body[k] = 8'($urandom_range(0, 255));
		end
		return body;
	endfunction

	// Reset, directed items, random items, drain and verdict.
	initial begin
		logic [PAYLOAD_BYTES-1:0][7:0] body;
		logic [7:0] b;
		int         pick;
		int         k;
		int         n;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Noise while hunting, then a bad second sync that is itself a first sync byte.
		send_byte(8'h00, 1'b1);
		send_byte(SYNC_FIRST, 1'b1);
		send_byte(SYNC_FIRST, 1'b1);
		// Good frame at the top of every field.
		body = '1;
		send_frame(8'hFF, body, 8'h00);
		// All-zero frame with a wrong checksum is dropped.
		body = '0;
		send_frame(8'h00, body, 8'hFF);

		// Hold off until every expected frame has come out.
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (frames_pending != 0) @(posedge clk);

		// Random stream: mostly frames with random content, some noise and broken frames.
		while (counted < ITEM_TARGET) begin
			if (counted >= CALM_FROM) begin
				calm <= 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 68) begin
				send_frame(8'($urandom_range(0, 255)), random_body(), 8'h00);
			end else if (pick < 80) begin
				send_frame(8'($urandom_range(0, 255)), random_body(),
					8'($urandom_range(1, 255)));
			end else if (pick < 88) begin
				n = $urandom_range(1, 4);
				for (k = 0; k < n; k++) begin
					send_byte(8'($urandom_range(0, 255)), 1'b0);
				end
			end else if (pick < 95) begin
				// First sync followed by anything but the second sync.
				send_byte(SYNC_FIRST, 1'b1);
				do begin
					b = 8'($urandom_range(0, 255));
				end while (b == SYNC_SECOND);
				send_byte(b, 1'b1);
			end else begin
				// Frame cut short; the next frame's bytes land inside it.
				body = random_body();
				send_byte(SYNC_FIRST, 1'b1);
				send_byte(SYNC_SECOND, 1'b1);
				send_byte(8'($urandom_range(0, 255)), 1'b1);
				n = $urandom_range(0, PAYLOAD_BYTES - 1);
				for (k = 0; k < n; k++) begin
					send_byte(body[k], 1'b1);
				end
			end
		end
		s_axis_tvalid <= 1'b0;
		calm <= 1'b1;

		// Drain, then allow for the block's latency.
		@(posedge clk);
		while (frames_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && frames_pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
